>>> rtl/ncm_pkg.sv
package ncm_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLOSE = 2'd2,
    OP_MOVE  = 2'd3
  } op_e;

  localparam int OP_W    = 2;
  localparam int FIELD_W = 4;   // start_node, target_node, symbol
  localparam int SET_W   = 16;  // node_set
  localparam int NIU_W   = 5;   // nodes_in_use register

  localparam logic [NIU_W-1:0] NIU_RESET = 5'd16;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

>>> rtl/nfa_closure_and_move_unit.sv
// NFA epsilon closure and move unit.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// clear the edge table, add an edge, take the epsilon closure of a state, or
// take the move of a state on a symbol. Every command gives exactly one
// result transaction on the output channel (out_valid_o / out_stall_i): a
// state bitmask and a status bit (1 = state or symbol out of range).
// The edge rows live in two RAMs, each with a write port and a registered read:
// one epsilon row per state and one row per (state, symbol) pair. Commands
// are processed one at a time; the input stalls while one is in flight.
// Add edge reads the row and writes it back with the new bit set. Closure and
// move do one RAM read and one merge per reached state; move first reads the
// symbol row and seeds from it. Clear zeroes both RAMs, sweeping the symbol
// RAM one row a cycle over its 2**(clog2(NODES)+clog2(SYMBOLS)) rows.
// Rejected commands go straight to the result. No new command is taken until
// the current one has written its result.
// After reset the same sweep runs once before the first command is taken;
// the configuration port is open throughout.
// The result register holds while out_stall_i is high; the next command may
// still be accepted and worked on, and waits only at its own completion.
module nfa_closure_and_move_unit #(
  parameter int NODES   = 16,
  parameter int SYMBOLS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [ncm_pkg::NIU_W-1:0]    cfg_wdata_i,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ncm_pkg::OP_W-1:0]     operation_i,
  input  logic [ncm_pkg::FIELD_W-1:0]  src_node_i,
  input  logic [ncm_pkg::FIELD_W-1:0]  target_node_i,
  input  logic [ncm_pkg::FIELD_W-1:0]  symbol_i,
  input  logic                         is_epsilon_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ncm_pkg::SET_W-1:0]    node_set_o,
  output logic                         status_o
);

  localparam int NODE_AW    = $clog2(NODES);
  localparam int SYM_AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SYM_ADDR_W = NODE_AW + SYM_AW;
  localparam int SET_W      = ncm_pkg::SET_W;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SYM_RD,
    ST_SYM_SEED,
    ST_CL_ISSUE,
    ST_CL_WAIT,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Edge RAMs
  // ---------------------------------------------------------------------------
  logic [NODES-1:0] eps_mem [2**NODE_AW];
  logic [NODES-1:0] sym_mem [2**SYM_ADDR_W];

  logic                  eps_we, eps_re;
  logic [NODE_AW-1:0]    eps_waddr, eps_raddr;
  logic [NODES-1:0]      eps_wdata, eps_rdata_q;
  logic                  sym_we, sym_re;
  logic [SYM_ADDR_W-1:0] sym_waddr, sym_raddr;
  logic [NODES-1:0]      sym_wdata, sym_rdata_q;

  always_ff @(posedge clk_i) begin
    if (eps_we) begin
      eps_mem[eps_waddr] <= eps_wdata;
    end
    if (eps_re) begin
      eps_rdata_q <= eps_mem[eps_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    if (sym_re) begin
      sym_rdata_q <= sym_mem[sym_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e                    state_q, state_d;
  logic [ncm_pkg::NIU_W-1:0] nodes_in_use_q, nodes_in_use_d;
  logic [SYM_ADDR_W-1:0]     cnt_q, cnt_d;
  logic [NODE_AW-1:0]        node_q, node_d;
  logic [NODE_AW-1:0]        tgt_q, tgt_d;
  logic [SYM_AW-1:0]         sym_q, sym_d;
  logic                      is_eps_q, is_eps_d;
  logic                      err_q, err_d;
  logic [NODES-1:0]          seen_q, seen_d;
  logic [NODES-1:0]          pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  logic [SET_W-1:0]          node_set_q, node_set_d;
  logic                      status_q, status_d;

  logic [NODES-1:0]   live;
  logic [NODE_AW-1:0] first;
  logic [NODES-1:0]   fresh;
  logic               s_ok, t_ok, sym_bad, in_err, in_acc;

  // states below nodes_in_use (values above NODES have no extra bits to set)
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      live[i] = (i < int'(nodes_in_use_q));
    end
  end

  // lowest pending state
  always_comb begin
    first = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        first = NODE_AW'(i);
      end
    end
  end

  assign fresh   = eps_rdata_q & live & ~seen_q;
  assign s_ok    = (int'(src_node_i) < int'(nodes_in_use_q)) && (int'(src_node_i) < NODES);
  assign t_ok    = (int'(target_node_i) < int'(nodes_in_use_q)) && (int'(target_node_i) < NODES);
  assign sym_bad = (int'(symbol_i) >= SYMBOLS);
  assign in_acc  = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (ncm_pkg::op_e'(operation_i))
      ncm_pkg::OP_CLEAR: in_err = 1'b0;
      ncm_pkg::OP_ADD:   in_err = !s_ok || !t_ok || (!is_epsilon_i && sym_bad);
      ncm_pkg::OP_CLOSE: in_err = !s_ok;
      ncm_pkg::OP_MOVE:  in_err = !s_ok || sym_bad;
      default:           in_err = 1'b1;
    endcase
  end

  always_comb begin
    state_d        = state_q;
    nodes_in_use_d = cfg_we_i ? cfg_wdata_i : nodes_in_use_q;
    cnt_d          = cnt_q;
    node_d         = node_q;
    tgt_d          = tgt_q;
    sym_d          = sym_q;
    is_eps_d       = is_eps_q;
    err_d          = err_q;
    seen_d         = seen_q;
    pend_d         = pend_q;
    out_valid_d    = out_valid_q && out_stall_i;
    node_set_d     = node_set_q;
    status_d       = status_q;

    eps_we    = 1'b0;
    eps_waddr = node_q;
    eps_wdata = eps_rdata_q | (NODES'(1) << tgt_q);
    eps_re    = 1'b0;
    eps_raddr = node_q;
    sym_we    = 1'b0;
    sym_waddr = {node_q, sym_q};
    sym_wdata = sym_rdata_q | (NODES'(1) << tgt_q);
    sym_re    = 1'b0;
    sym_raddr = {node_q, sym_q};

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        eps_we    = 1'b1;
        eps_waddr = cnt_q[NODE_AW-1:0];
        eps_wdata = '0;
        sym_we    = 1'b1;
        sym_waddr = cnt_q;
        sym_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          node_d   = NODE_AW'(src_node_i);
          tgt_d    = NODE_AW'(target_node_i);
          sym_d    = SYM_AW'(symbol_i);
          is_eps_d = is_epsilon_i;
          err_d    = in_err;
          seen_d   = '0;
          if (in_err) begin
            state_d = ST_DONE;
          end else begin
            unique case (ncm_pkg::op_e'(operation_i))
              ncm_pkg::OP_CLEAR: begin
                cnt_d   = '0;
                state_d = ST_CLEAR;
              end
              ncm_pkg::OP_ADD: state_d = ST_ADD_RD;
              ncm_pkg::OP_CLOSE: begin
                seen_d  = NODES'(1) << NODE_AW'(src_node_i);
                pend_d  = NODES'(1) << NODE_AW'(src_node_i);
                state_d = ST_CL_ISSUE;
              end
              ncm_pkg::OP_MOVE: state_d = ST_SYM_RD;
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_ADD_RD: begin
        eps_re  = is_eps_q;
        sym_re  = !is_eps_q;
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        eps_we  = is_eps_q;
        sym_we  = !is_eps_q;
        state_d = ST_DONE;
      end
      ST_SYM_RD: begin
        sym_re  = 1'b1;
        state_d = ST_SYM_SEED;
      end
      ST_SYM_SEED: begin
        seen_d  = sym_rdata_q & live;
        pend_d  = sym_rdata_q & live;
        state_d = ST_CL_ISSUE;
      end
      ST_CL_ISSUE: begin
        if (pend_q == '0) begin
          state_d = ST_DONE;
        end else begin
          eps_re    = 1'b1;
          eps_raddr = first;
          pend_d    = pend_q & ~(NODES'(1) << first);
          state_d   = ST_CL_WAIT;
        end
      end
      ST_CL_WAIT: begin
        // follow only edges into live states not yet reached
        seen_d  = seen_q | fresh;
        pend_d  = pend_q | fresh;
        state_d = ST_CL_ISSUE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          node_set_d  = SET_W'(seen_q);
          status_d    = err_q ? ncm_pkg::STATUS_ERR : ncm_pkg::STATUS_OK;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      nodes_in_use_q <= ncm_pkg::NIU_RESET;
      cnt_q          <= '0;
      node_q         <= '0;
      tgt_q          <= '0;
      sym_q          <= '0;
      is_eps_q       <= 1'b0;
      err_q          <= 1'b0;
      seen_q         <= '0;
      pend_q         <= '0;
      out_valid_q    <= 1'b0;
      node_set_q     <= '0;
      status_q       <= ncm_pkg::STATUS_OK;
    end else begin
      state_q        <= state_d;
      nodes_in_use_q <= nodes_in_use_d;
      cnt_q          <= cnt_d;
      node_q         <= node_d;
      tgt_q          <= tgt_d;
      sym_q          <= sym_d;
      is_eps_q       <= is_eps_d;
      err_q          <= err_d;
      seen_q         <= seen_d;
      pend_q         <= pend_d;
      out_valid_q    <= out_valid_d;
      node_set_q     <= node_set_d;
      status_q       <= status_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign node_set_o  = node_set_q;
  assign status_o    = status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_err && (operation_i == ncm_pkg::OP_CLEAR) |=> state_q == ST_CLEAR)
    else $error("clear transaction did not start the sweep");

  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ncm_pkg::STATUS_ERR) |-> node_set_o == '0)
    else $error("error result carries a non-empty set");

  a_pend_in_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CL_ISSUE || state_q == ST_CL_WAIT) |-> (pend_q & ~seen_q) == '0)
    else $error("pending state outside visited set");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("result appeared without a completed transaction");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NODE_COUNT     = 16;
  localparam int SYMBOL_COUNT   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 300;  // longer than a full clear sweep

  typedef enum logic {
    ENTRY_CMD,
    ENTRY_CFG
  } entry_e;

  typedef struct {
    entry_e                      kind;
    ncm_pkg::op_e                op;
    logic [ncm_pkg::FIELD_W-1:0] src_node;
    logic [ncm_pkg::FIELD_W-1:0] target_node;
    logic [ncm_pkg::FIELD_W-1:0] symbol;
    logic                        is_eps;
    logic [ncm_pkg::NIU_W-1:0]   niu;
    int                          gap;
    logic                        calm;
  } cmd_t;

  typedef struct {
    logic [ncm_pkg::SET_W-1:0] node_set;
    logic                      status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        cfg_we_i      = 1'b0;
  logic [ncm_pkg::NIU_W-1:0]   cfg_wdata_i   = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [ncm_pkg::OP_W-1:0]    operation_i   = '0;
  logic [ncm_pkg::FIELD_W-1:0] src_node_i    = '0;
  logic [ncm_pkg::FIELD_W-1:0] target_node_i = '0;
  logic [ncm_pkg::FIELD_W-1:0] symbol_i      = '0;
  logic                        is_epsilon_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [ncm_pkg::SET_W-1:0]   node_set_o;
  logic                        status_o;

  nfa_closure_and_move_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .src_node_i    (src_node_i),
    .target_node_i (target_node_i),
    .symbol_i      (symbol_i),
    .is_epsilon_i  (is_epsilon_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .node_set_o    (node_set_o),
    .status_o      (status_o)
  );

  // predictor state
  logic [ncm_pkg::SET_W-1:0] eps_rows [NODE_COUNT] = '{default: '0};
  logic [ncm_pkg::SET_W-1:0] sym_rows [NODE_COUNT*SYMBOL_COUNT] = '{default: '0};
  logic [ncm_pkg::NIU_W-1:0] live_count = ncm_pkg::NIU_RESET;

  cmd_t    pending_cmds[$];
  result_t expected_sets[$];

  logic phase_calm = 1'b0;
  logic rx_calm    = 1'b0;
  logic in_taken   = 1'b0;
  int   stall_left = 0;
  int   faults     = 0;
  int   quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [ncm_pkg::SET_W-1:0] close_over_epsilon(
      logic [ncm_pkg::SET_W-1:0] seed, logic [ncm_pkg::SET_W-1:0] live);
    logic [ncm_pkg::SET_W-1:0] reached;
    logic [ncm_pkg::SET_W-1:0] grown;
    grown = seed & live;
    do begin
      reached = grown;
      for (int i = 0; i < NODE_COUNT; i++)
        if (reached[i]) grown |= eps_rows[i] & live;
    end while (grown != reached);
    return reached;
  endfunction

  function automatic result_t apply_command(cmd_t c);
    result_t                   r;
    int                        n;
    logic [ncm_pkg::SET_W-1:0] live;
    logic [7:0]                row;
    r.node_set = '0;
    r.status   = ncm_pkg::STATUS_OK;
    n    = (int'(live_count) > NODE_COUNT) ? NODE_COUNT : int'(live_count);
    live = (n >= ncm_pkg::SET_W) ? '1 : ncm_pkg::SET_W'((32'd1 << n) - 32'd1);
    row  = {c.src_node, c.symbol};
    case (c.op)
      ncm_pkg::OP_CLEAR: begin
        for (int i = 0; i < NODE_COUNT; i++) eps_rows[i] = '0;
        for (int i = 0; i < NODE_COUNT*SYMBOL_COUNT; i++) sym_rows[i] = '0;
      end
      ncm_pkg::OP_ADD: begin
        if (int'(c.src_node) >= n || int'(c.target_node) >= n ||
            (!c.is_eps && int'(c.symbol) >= SYMBOL_COUNT))
          r.status = ncm_pkg::STATUS_ERR;
        else if (c.is_eps)
          eps_rows[c.src_node][c.target_node] = 1'b1;
        else
          sym_rows[row][c.target_node] = 1'b1;
      end
      ncm_pkg::OP_CLOSE: begin
        if (int'(c.src_node) >= n)
          r.status = ncm_pkg::STATUS_ERR;
        else
          r.node_set = close_over_epsilon(ncm_pkg::SET_W'(1) << c.src_node, live);
      end
      default: begin
        if (int'(c.src_node) >= n || int'(c.symbol) >= SYMBOL_COUNT)
          r.status = ncm_pkg::STATUS_ERR;
        else
          r.node_set = close_over_epsilon(sym_rows[row], live);
      end
    endcase
    return r;
  endfunction

  task automatic report_fault(string what);
    faults++;
    if (faults <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic push_cmd(ncm_pkg::op_e op, int s, int t, int sym, logic eps);
    cmd_t c;
    c.kind        = ENTRY_CMD;
    c.op          = op;
    c.src_node    = ncm_pkg::FIELD_W'(s);
    c.target_node = ncm_pkg::FIELD_W'(t);
    c.symbol      = ncm_pkg::FIELD_W'(sym);
    c.is_eps      = eps;
    c.niu         = '0;
    c.calm        = phase_calm;
    c.gap         = phase_calm ? 0 : $urandom_range(0, 15);
    pending_cmds.push_back(c);
  endtask

  // the driver holds a register write back until every result is in
  task automatic push_cfg(int value);
    cmd_t c;
    c.kind        = ENTRY_CFG;
    c.op          = ncm_pkg::OP_CLEAR;
    c.src_node    = '0;
    c.target_node = '0;
    c.symbol      = '0;
    c.is_eps      = 1'b0;
    c.niu         = ncm_pkg::NIU_W'(value);
    c.calm        = phase_calm;
    c.gap         = 0;
    pending_cmds.push_back(c);
  endtask

  function automatic int pick_node(int n_eff);
    if (n_eff == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, n_eff - 1);
  endfunction

  // driver: items and register writes, launched on the falling edge
  always @(negedge clk_i) begin
    logic hold_valid;
    logic write_cfg;
    cmd_t head;
    hold_valid = in_valid_i && !in_taken;
    write_cfg  = 1'b0;
    if (rst_ni && !hold_valid && pending_cmds.size() > 0) begin
      head = pending_cmds[0];
      if (head.kind == ENTRY_CFG) begin
        if (expected_sets.size() == 0) begin
          write_cfg = 1'b1;
          cfg_wdata_i <= head.niu;
          void'(pending_cmds.pop_front());
        end
      end else if (head.gap > 0) begin
        pending_cmds[0].gap = head.gap - 1;
      end else begin
        hold_valid = 1'b1;
        operation_i   <= head.op;
        src_node_i    <= head.src_node;
        target_node_i <= head.target_node;
        symbol_i      <= head.symbol;
        is_epsilon_i  <= head.is_eps;
        rx_calm = head.calm;
        void'(pending_cmds.pop_front());
      end
    end
    in_valid_i  <= hold_valid;
    cfg_we_i    <= write_cfg;
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // monitor: predicts on every accepted command, checks every result
  always @(posedge clk_i) begin
    cmd_t    seen;
    result_t want;
    if (rst_ni) begin
      if (cfg_we_i) live_count = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        seen.kind        = ENTRY_CMD;
        seen.op          = ncm_pkg::op_e'(operation_i);
        seen.src_node    = src_node_i;
        seen.target_node = target_node_i;
        seen.symbol      = symbol_i;
        seen.is_eps      = is_epsilon_i;
        seen.niu         = '0;
        seen.gap         = 0;
        seen.calm        = 1'b0;
        expected_sets.push_back(apply_command(seen));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_sets.size() == 0) begin
          report_fault($sformatf("unrequested transaction: node_set %h status %b",
                                 node_set_o, status_o));
        end else begin
          want = expected_sets.pop_front();
          if (node_set_o !== want.node_set)
            report_fault($sformatf("node_set expected %h got %h",
                                   want.node_set, node_set_o));
          if (status_o !== want.status)
            report_fault($sformatf("status expected %b got %b (node_set %h)",
                                   want.status, status_o, node_set_o));
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 15);
      end
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("nfa_closure_and_move_unit test failed");
      $finish;
    end
  end

  initial begin
    int total;
    int phase;
    int niu;
    int n_eff;
    int len;
    int sym_hi;
    int pick;

    // directed: epsilon cycle 0 -> 1 -> 2 -> 0, symbol edges, range checks
    push_cfg(16);
    push_cmd(ncm_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_ADD, 0, 1, 0, 1'b1);
    push_cmd(ncm_pkg::OP_ADD, 1, 2, 0, 1'b1);
    push_cmd(ncm_pkg::OP_ADD, 2, 0, 0, 1'b1);
    push_cmd(ncm_pkg::OP_ADD, 2, 3, 15, 1'b1);   // symbol ignored on epsilon edges
    push_cmd(ncm_pkg::OP_ADD, 0, 5, 0, 1'b0);
    push_cmd(ncm_pkg::OP_ADD, 5, 6, 0, 1'b1);
    push_cmd(ncm_pkg::OP_ADD, 15, 15, 15, 1'b0);
    push_cmd(ncm_pkg::OP_CLOSE, 0, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_CLOSE, 15, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_MOVE, 0, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_MOVE, 15, 0, 15, 1'b0);
    push_cmd(ncm_pkg::OP_MOVE, 3, 0, 4, 1'b0);
    // shrink: edges to 5 and 6 go stale
    push_cfg(4);
    push_cmd(ncm_pkg::OP_CLOSE, 0, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_MOVE, 0, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_ADD, 4, 0, 0, 1'b1);
    push_cmd(ncm_pkg::OP_ADD, 0, 4, 1, 1'b0);
    push_cmd(ncm_pkg::OP_CLOSE, 4, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_MOVE, 7, 0, 0, 1'b0);
    push_cfg(0);
    push_cmd(ncm_pkg::OP_CLOSE, 0, 0, 0, 1'b0);
    push_cmd(ncm_pkg::OP_ADD, 0, 0, 0, 1'b1);
    push_cmd(ncm_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    push_cfg(31);
    push_cmd(ncm_pkg::OP_ADD, 15, 0, 0, 1'b1);
    push_cmd(ncm_pkg::OP_CLOSE, 15, 0, 0, 1'b0);

    total = 0;
    phase = 0;
    while (total < 1700) begin
      case (phase)
        0:       niu = 16;
        1:       niu = 1;
        2:       niu = 0;
        3:       niu = 31;
        4:       niu = 2;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0)      niu = 0;
          else if (pick == 1) niu = $urandom_range(17, 31);
          else                niu = $urandom_range(1, 16);
        end
      endcase
      n_eff = (niu > NODE_COUNT) ? NODE_COUNT : niu;
      phase_calm = ($urandom_range(0, 3) == 0);
      sym_hi = ($urandom_range(0, 2) == 0) ? 15 : $urandom_range(0, 3);
      len = (niu == 0) ? 30 : $urandom_range(60, 140);
      push_cfg(niu);
      if ($urandom_range(0, 1) == 0) push_cmd(ncm_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)
          push_cmd(ncm_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        else if (pick < 45)
          push_cmd(ncm_pkg::OP_ADD, pick_node(n_eff), pick_node(n_eff),
                   $urandom_range(0, sym_hi), 1'($urandom_range(0, 1)));
        else if (pick < 72)
          push_cmd(ncm_pkg::OP_CLOSE, pick_node(n_eff), $urandom_range(0, 15),
                   $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        else
          push_cmd(ncm_pkg::OP_MOVE, pick_node(n_eff), $urandom_range(0, 15),
                   $urandom_range(0, sym_hi), 1'($urandom_range(0, 1)));
      end
      total += len;
      phase++;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || in_valid_i || expected_sets.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (faults == 0 && expected_sets.size() == 0)
      $display("nfa_closure_and_move_unit test passed");
    else
      $display("nfa_closure_and_move_unit test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/ncm_pkg.sv
rtl/nfa_closure_and_move_unit.sv
tb/testbench.sv
